// ===== hw/rtl/overwriting_message_fifo_top_defines.svh =====
// Assertion macros for the overwriting message FIFO.
// Each macro takes a label, the clock, the synchronous reset and the property terms.
`ifndef OVERWRITING_MESSAGE_FIFO_TOP_DEFINES_SVH
`define OVERWRITING_MESSAGE_FIFO_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define OVMSG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ovmsg assertion failed");

`define OVMSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ovmsg assertion failed");

`else

`define OVMSG_ASSERT_SAME(label, clk, rst, ante, cons)
`define OVMSG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/ovmsg_pkg.sv =====
`default_nettype none

package ovmsg_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CODE_W    = 16;
  localparam int PAYLOAD_W = 32;
  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_POST   = 2'd0,
    MODE_GET    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  // Register select taken from the word address bit
  localparam logic REG_EMPTY_CODE = 1'b0;
  localparam logic REG_STICKY     = 1'b1;

  localparam logic [CODE_W-1:0] EMPTY_CODE_RESET = 16'h0000;
  localparam logic [CODE_W-1:0] STICKY_RESET     = 16'hFFFF;

endpackage

`default_nettype wire

// ===== hw/rtl/overwriting_message_fifo_top.sv =====
// Each input transfer moves the control from idle to the response state, which
// registers the result from the registered read of the entry memory and updates
// the read index; no new input is taken until the response state has finished.
// A waiting result does not block the next input transfer.
// Reset (synchronous, active high) empties the queue and loads the register defaults;
// the entry memory is not cleared.
`default_nettype none

`include "overwriting_message_fifo_top_defines.svh"

module overwriting_message_fifo_top #(
  parameter int DEPTH = ovmsg_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ovmsg_pkg::MODE_W-1:0]      mode,
  input  wire logic [ovmsg_pkg::CODE_W-1:0]      message_code,
  input  wire logic [ovmsg_pkg::PAYLOAD_W-1:0]   payload,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [ovmsg_pkg::CODE_W-1:0]           head_code,
  output logic [ovmsg_pkg::PAYLOAD_W-1:0]        head_payload,
  output logic                                   was_empty,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ovmsg_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [ovmsg_pkg::DATA_W-1:0]      pwdata,
  output logic [ovmsg_pkg::DATA_W-1:0]           prdata,
  output logic                                   pready
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  state_t                             state;
  ovmsg_pkg::mode_t                   op_mode;
  logic                               op_empty;
  logic [IDX_W-1:0]                   write_index;
  logic [IDX_W-1:0]                   read_index;
  logic [ovmsg_pkg::CODE_W-1:0]       empty_code;
  logic [ovmsg_pkg::CODE_W-1:0]       sticky_threshold;

  logic [ovmsg_pkg::CODE_W-1:0]       code_mem    [DEPTH];
  logic [ovmsg_pkg::PAYLOAD_W-1:0]    payload_mem [DEPTH];
  logic [ovmsg_pkg::CODE_W-1:0]       rd_code;
  logic [ovmsg_pkg::PAYLOAD_W-1:0]    rd_payload;

  logic                               in_xfer;
  logic                               cfg_write;
  logic                               do_post;
  logic [IDX_W-1:0]                   write_index_next;
  logic [IDX_W-1:0]                   read_index_inc;
  logic                               pop;
  logic                               head_shown;
  logic                               resp_fire;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(DEPTH - 1)) begin
      next_idx = '0;
    end else begin
      next_idx = i + 1'b1;
    end
  endfunction

  assign pready    = 1'b1;
  assign in_stall  = (state == ST_RESP);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;

  assign do_post = in_xfer && (ovmsg_pkg::mode_t'(mode) == ovmsg_pkg::MODE_POST) &&
                   (message_code != empty_code);
  assign write_index_next = next_idx(write_index);
  assign read_index_inc   = next_idx(read_index);

  // get pops only codes below the threshold; remove always pops a non-empty head
  assign pop = !op_empty &&
               (((op_mode == ovmsg_pkg::MODE_GET) && (rd_code < sticky_threshold)) ||
                (op_mode == ovmsg_pkg::MODE_REMOVE));
  assign head_shown = !op_empty &&
                      ((op_mode == ovmsg_pkg::MODE_GET) || (op_mode == ovmsg_pkg::MODE_PEEK));

  // hold while the previous result is still stalled
  assign resp_fire = (state == ST_RESP) && (!out_valid || !out_stall);

  always_comb begin
    unique case (paddr[2])
      ovmsg_pkg::REG_EMPTY_CODE: prdata = {{(ovmsg_pkg::DATA_W - ovmsg_pkg::CODE_W){1'b0}},
                                           empty_code};
      ovmsg_pkg::REG_STICKY:     prdata = {{(ovmsg_pkg::DATA_W - ovmsg_pkg::CODE_W){1'b0}},
                                           sticky_threshold};
      default:                   prdata = '0;
    endcase
  end

  // Entry memory: one write port for posts, one registered read of the head
  always_ff @(posedge clk) begin
    if (do_post) begin
      code_mem[write_index]    <= message_code;
      payload_mem[write_index] <= payload;
    end
    if (in_xfer) begin
      rd_code    <= code_mem[read_index];
      rd_payload <= payload_mem[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      write_index      <= '0;
      read_index       <= '0;
      empty_code       <= ovmsg_pkg::EMPTY_CODE_RESET;
      sticky_threshold <= ovmsg_pkg::STICKY_RESET;
      op_mode          <= ovmsg_pkg::MODE_POST;
      op_empty         <= 1'b0;
      head_code        <= '0;
      head_payload     <= '0;
      was_empty        <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == ovmsg_pkg::REG_EMPTY_CODE) begin
          empty_code <= pwdata[ovmsg_pkg::CODE_W-1:0];
        end else begin
          sticky_threshold <= pwdata[ovmsg_pkg::CODE_W-1:0];
        end
      end

      if (resp_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            op_mode  <= ovmsg_pkg::mode_t'(mode);
            op_empty <= (write_index == read_index);
            if (do_post) begin
              write_index <= write_index_next;
              // full queue: drop the oldest entry
              if (write_index_next == read_index) begin
                read_index <= read_index_inc;
              end
            end
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (resp_fire) begin
            head_code    <= head_shown ? rd_code : empty_code;
            head_payload <= head_shown ? rd_payload : '0;
            was_empty    <= op_empty;
            if (pop) begin
              read_index <= read_index_inc;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `OVMSG_ASSERT_SAME(a_no_xfer_in_resp, clk, rst, state == ST_RESP, in_stall)
  `OVMSG_ASSERT_NEXT(a_xfer_to_resp, clk, rst, in_xfer, state == ST_RESP)
  `OVMSG_ASSERT_NEXT(a_post_not_empty, clk, rst, do_post, write_index != read_index)
  `OVMSG_ASSERT_NEXT(a_resp_holds, clk, rst,
    (state == ST_RESP) && out_valid && out_stall, state == ST_RESP)

endmodule

`default_nettype wire

// ===== tb/overwriting_message_fifo_checker.sv =====
module overwriting_message_fifo_checker
  import ovmsg_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [MODE_W-1:0]    mode,
  input  logic [CODE_W-1:0]    message_code,
  input  logic [PAYLOAD_W-1:0] payload,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CODE_W-1:0]    head_code,
  input  logic [PAYLOAD_W-1:0] head_payload,
  input  logic                 was_empty,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  input  logic                 pready,
  output int                   outstanding,
  output int                   fault_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic [PAYLOAD_W-1:0] word;
    logic                 empty;
  } head_result_t;

  logic [CODE_W-1:0]    entry_code [DEPTH];
  logic [PAYLOAD_W-1:0] entry_word [DEPTH];
  int                   wr_idx;
  int                   rd_idx;
  logic [CODE_W-1:0]    cfg_empty;
  logic [CODE_W-1:0]    cfg_sticky;
  head_result_t         awaited_heads [$];
  int                   fault_total;

  initial begin
    fault_total = 0;
  end

  function automatic head_result_t apply_queue_op(input mode_t op,
                                                  input logic [CODE_W-1:0] code,
                                                  input logic [PAYLOAD_W-1:0] word);
    head_result_t r;
    logic         empty;
    empty   = (wr_idx == rd_idx);
    r.code  = cfg_empty;
    r.word  = '0;
    r.empty = empty;
    case (op)
      MODE_POST: begin
        if (code != cfg_empty) begin
          entry_code[wr_idx] = code;
          entry_word[wr_idx] = word;
          wr_idx = (wr_idx + 1) % DEPTH;
          // full queue: drop the oldest entry
          if (wr_idx == rd_idx) rd_idx = (rd_idx + 1) % DEPTH;
        end
      end
      MODE_GET: begin
        if (!empty) begin
          r.code = entry_code[rd_idx];
          r.word = entry_word[rd_idx];
          if (r.code < cfg_sticky) rd_idx = (rd_idx + 1) % DEPTH;
        end
      end
      MODE_PEEK: begin
        if (!empty) begin
          r.code = entry_code[rd_idx];
          r.word = entry_word[rd_idx];
        end
      end
      default: begin
        if (!empty) rd_idx = (rd_idx + 1) % DEPTH;
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, label, want, got);
      fault_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    head_result_t want;
    if (rst) begin
      wr_idx     = 0;
      rd_idx     = 0;
      cfg_empty  = EMPTY_CODE_RESET;
      cfg_sticky = STICKY_RESET;
      awaited_heads.delete();
    end else begin
      // compare before predicting: a result never belongs to the transfer at the same edge
      if (out_valid && !out_stall) begin
        if (awaited_heads.size() == 0) begin
          $display("%0t unexpected result: expected none, actual code %0h payload %0h empty %0b",
                   $time, head_code, head_payload, was_empty);
          fault_total++;
        end else begin
          want = awaited_heads.pop_front();
          compare_field("head_code", 32'(want.code), 32'(head_code));
          compare_field("head_payload", want.word, head_payload);
          compare_field("was_empty", 32'(want.empty), 32'(was_empty));
        end
      end
      if (in_valid && !in_stall)
        awaited_heads.push_back(apply_queue_op(mode_t'(mode), message_code, payload));
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_EMPTY_CODE) cfg_empty = pwdata[CODE_W-1:0];
        else cfg_sticky = pwdata[CODE_W-1:0];
      end
    end
    outstanding <= awaited_heads.size();
    fault_count <= fault_total;
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import ovmsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    mode = '0;
  logic [CODE_W-1:0]    message_code = '0;
  logic [PAYLOAD_W-1:0] payload = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CODE_W-1:0]    head_code;
  logic [PAYLOAD_W-1:0] head_payload;
  logic                 was_empty;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  int                   outstanding;
  int                   fault_count;
  int                   burst_left = 0;
  int                   stall_left = 0;
  int                   stall_style = 0;
  int                   cycle_count = 0;
  logic [CODE_W-1:0]    cur_empty = EMPTY_CODE_RESET;
  logic [CODE_W-1:0]    cur_sticky = STICKY_RESET;

  overwriting_message_fifo_top dut (
    .clk, .rst,
    .in_valid, .in_stall, .mode, .message_code, .payload,
    .out_valid, .out_stall, .head_code, .head_payload, .was_empty,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  overwriting_message_fifo_checker checker_i (
    .clk, .rst,
    .in_valid, .in_stall, .mode, .message_code, .payload,
    .out_valid, .out_stall, .head_code, .head_payload, .was_empty,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .outstanding, .fault_count
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("overwriting_message_fifo_top verification failed");
      $finish;
    end
  end

  // receiver: switch between stall styles after each randomly drawn stretch
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= stall_left[2];
    endcase
  end

  task automatic send_item(input mode_t m, input logic [CODE_W-1:0] c,
                           input logic [PAYLOAD_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    message_code <= c;
    payload      <= p;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // drop valid and hold until every result has been taken
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [CODE_W-1:0] value);
    logic [DATA_W-1:0] noise;
    noise   = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    // upper bits are junk and must be ignored
    pwdata  <= {noise[DATA_W-1:CODE_W], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (reg_sel == REG_EMPTY_CODE) cur_empty = value;
    else cur_sticky = value;
  endtask

  task automatic run_traffic(input int count);
    int                   episode_left;
    int                   post_pct;
    mode_t                m;
    logic [CODE_W-1:0]    c;
    logic [PAYLOAD_W-1:0] p;
    episode_left = 0;
    post_pct     = 50;
    repeat (count) begin
      // switch at random among fill-heavy, drain-heavy and balanced stretches to hit full and empty
      if (episode_left == 0) begin
        episode_left = $urandom_range(4, 30);
        case ($urandom_range(0, 2))
          0: post_pct = 80;
          1: post_pct = 20;
          default: post_pct = 50;
        endcase
      end
      episode_left--;
      if ($urandom_range(0, 99) < post_pct) begin
        m = MODE_POST;
      end else begin
        case ($urandom_range(0, 2))
          0: m = MODE_GET;
          1: m = MODE_PEEK;
          default: m = MODE_REMOVE;
        endcase
      end
      case ($urandom_range(0, 7))
        0: c = cur_empty;
        1: c = cur_sticky;
        2: c = cur_sticky - 1'b1;
        3: c = '0;
        4: c = '1;
        default: c = CODE_W'($urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(0, 5))
        0: p = '0;
        1: p = '1;
        default: p = $urandom();
      endcase
      send_item(m, c, p);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue: get, peek and remove see nothing
    send_item(MODE_GET, '1, '1);
    send_item(MODE_PEEK, '1, '1);
    send_item(MODE_REMOVE, '0, '0);
    // post of the no-message code is dropped
    send_item(MODE_POST, 16'h0000, '1);
    send_item(MODE_POST, 16'hFFFF, '1);
    send_item(MODE_POST, 16'h0001, '0);
    // top code sits at the threshold and stays on get
    send_item(MODE_GET, '0, '0);
    send_item(MODE_REMOVE, '0, '0);
    send_item(MODE_GET, '0, '0);
    // overfill: the last post pushes out the oldest entry
    for (int i = 1; i <= 16; i++) send_item(MODE_POST, CODE_W'(i), $urandom());
    send_item(MODE_PEEK, '0, '0);
    send_item(MODE_GET, '0, '0);
    wait_idle();

    apb_write(REG_EMPTY_CODE, 16'hFFFF);
    apb_write(REG_STICKY, 16'h0000);
    run_traffic(110);
    wait_idle();

    apb_write(REG_EMPTY_CODE, CODE_W'($urandom_range(1, 16'hFFFE)));
    apb_write(REG_STICKY, 16'h8000);
    run_traffic(110);
    wait_idle();

    apb_write(REG_EMPTY_CODE, 16'h0000);
    apb_write(REG_STICKY, 16'hFFFF);
    run_traffic(110);
    wait_idle();

    apb_write(REG_EMPTY_CODE, CODE_W'($urandom_range(0, 16'hFFFF)));
    apb_write(REG_STICKY, CODE_W'($urandom_range(0, 16'hFFFF)));
    run_traffic(100);
    wait_idle();

    if (fault_count == 0 && outstanding == 0) begin
      $display("overwriting_message_fifo_top verification clean");
    end else begin
      $display("overwriting_message_fifo_top verification failed");
    end
    $finish;
  end

endmodule
